// ===== src/qfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// qfpa_pkg
// Shared types, codes and helpers for the quad/fan primitive assembler.
// ----------------------------------------------------------------------------
package qfpa_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned JOB_RECS = 4;
    localparam int unsigned STEP_W   = 3;

    localparam logic [WORD_W-1:0] ONE_F32 = 32'h3F80_0000;

    typedef enum logic [2:0] {
        OP_BEGIN  = 3'd0,
        OP_RGBA   = 3'd1,
        OP_RGB    = 3'd2,
        OP_TEX    = 3'd3,
        OP_VERTEX = 3'd4
    } op_e;

    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_QUADS = 2'd1;
    localparam logic [1:0] MODE_FAN   = 2'd2;

    localparam logic [1:0] QUAD_LAST = 2'd3;
    localparam logic [1:0] FAN_NONE  = 2'd0;
    localparam logic [1:0] FAN_ONE   = 2'd1;
    localparam logic [1:0] FAN_FULL  = 2'd2;

    typedef enum logic [1:0] {
        JOB_PASS = 2'd0,
        JOB_FAN  = 2'd1,
        JOB_QUAD = 2'd2
    } job_kind_e;

    localparam logic [STEP_W-1:0] CNT_PASS = 3'd1;
    localparam logic [STEP_W-1:0] CNT_FAN  = 3'd3;
    localparam logic [STEP_W-1:0] CNT_QUAD = 3'd6;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        prim_mode;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] tex_v;
        logic [WORD_W-1:0] col_r;
        logic [WORD_W-1:0] col_g;
        logic [WORD_W-1:0] col_b;
        logic [WORD_W-1:0] col_a;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_x;
        logic [WORD_W-1:0] out_y;
        logic [WORD_W-1:0] out_z;
        logic [WORD_W-1:0] out_u;
        logic [WORD_W-1:0] out_v;
        logic [WORD_W-1:0] out_r;
        logic [WORD_W-1:0] out_g;
        logic [WORD_W-1:0] out_b;
        logic [WORD_W-1:0] out_a;
        logic              last_of_run;
    } out_item_t;

    // one assembled vertex
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] u;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] g;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] a;
    } rec_t;

    typedef struct packed {
        job_kind_e          kind;
        rec_t [JOB_RECS-1:0] recs;
    } job_t;

    function automatic logic [STEP_W-1:0] job_count(input job_kind_e kind);
        logic [STEP_W-1:0] cnt;
        unique case (kind)
            JOB_QUAD: cnt = CNT_QUAD;
            JOB_FAN:  cnt = CNT_FAN;
            default:  cnt = CNT_PASS;
        endcase
        return cnt;
    endfunction

    // quads go out as 0,1,2 then 0,2,3; fan and pass-through in order
    function automatic logic [1:0] rec_slot(input job_kind_e kind,
                                            input logic [STEP_W-1:0] step);
        logic [1:0] slot;
        if (kind == JOB_QUAD) begin
            unique case (step)
                3'd0:    slot = 2'd0;
                3'd1:    slot = 2'd1;
                3'd2:    slot = 2'd2;
                3'd3:    slot = 2'd0;
                3'd4:    slot = 2'd2;
                default: slot = 2'd3;
            endcase
        end else begin
            slot = step[1:0];
        end
        return slot;
    endfunction

endpackage

// ===== src/qfpa_state.sv =====
// ----------------------------------------------------------------------------
// qfpa_state
// Attribute latches and quad/fan assembly stores; builds the output job.
// ----------------------------------------------------------------------------
module qfpa_state import qfpa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     accept_i,
    input  in_item_t item_i,
    output logic     emits_o,
    output job_t     job_o
);

    logic [1:0]        mode_reg;
    logic [WORD_W-1:0] tex_reg [2];
    logic [WORD_W-1:0] col_reg [4];
    rec_t              quad_reg [3];
    logic [1:0]        quad_fill_reg;
    rec_t              fan_first_reg;
    rec_t              fan_prev_reg;
    logic [1:0]        fan_seen_reg;
    rec_t              rec;
    logic              is_vertex;

    assign is_vertex = (item_i.op == OP_VERTEX);

    // record for an incoming vertex uses the latched attributes
    always_comb begin
        rec.x = item_i.pos_x;
        rec.y = item_i.pos_y;
        rec.z = item_i.pos_z;
        rec.u = tex_reg[0];
        rec.v = tex_reg[1];
        rec.r = col_reg[0];
        rec.g = col_reg[1];
        rec.b = col_reg[2];
        rec.a = col_reg[3];
    end

    always_comb begin
        job_o.recs = {JOB_RECS{rec}};
        job_o.kind = JOB_PASS;
        emits_o    = 1'b0;
        if (mode_reg == MODE_QUADS) begin
            job_o.kind    = JOB_QUAD;
            job_o.recs[0] = quad_reg[0];
            job_o.recs[1] = quad_reg[1];
            job_o.recs[2] = quad_reg[2];
            emits_o       = is_vertex && (quad_fill_reg == QUAD_LAST);
        end else if (mode_reg == MODE_FAN) begin
            job_o.kind    = JOB_FAN;
            job_o.recs[0] = fan_first_reg;
            job_o.recs[1] = fan_prev_reg;
            emits_o       = is_vertex && (fan_seen_reg == FAN_FULL);
        end else begin
            emits_o = is_vertex;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_PASS;
            tex_reg[0]    <= '0;
            tex_reg[1]    <= '0;
            col_reg[0]    <= ONE_F32;
            col_reg[1]    <= ONE_F32;
            col_reg[2]    <= ONE_F32;
            col_reg[3]    <= ONE_F32;
            quad_fill_reg <= '0;
            fan_seen_reg  <= FAN_NONE;
        end else if (accept_i) begin
            unique case (item_i.op)
                OP_BEGIN: begin
                    mode_reg      <= item_i.prim_mode;
                    quad_fill_reg <= '0;
                    fan_seen_reg  <= FAN_NONE;
                end
                OP_RGBA, OP_RGB: begin
                    col_reg[0] <= item_i.col_r;
                    col_reg[1] <= item_i.col_g;
                    col_reg[2] <= item_i.col_b;
                    col_reg[3] <= (item_i.op == OP_RGBA) ? item_i.col_a : ONE_F32;
                end
                OP_TEX: begin
                    tex_reg[0] <= item_i.tex_u;
                    tex_reg[1] <= item_i.tex_v;
                end
                OP_VERTEX: begin
                    if (mode_reg == MODE_QUADS) begin
                        quad_fill_reg <= quad_fill_reg + 2'd1;
                    end else if (mode_reg == MODE_FAN) begin
                        if (fan_seen_reg != FAN_FULL) begin
                            fan_seen_reg <= fan_seen_reg + 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // record stores, no reset: counters guard every read
    always_ff @(posedge aclk) begin
        if (accept_i && is_vertex) begin
            if (mode_reg == MODE_QUADS) begin
                if (quad_fill_reg != QUAD_LAST) begin
                    quad_reg[quad_fill_reg] <= rec;
                end
            end else if (mode_reg == MODE_FAN) begin
                if (fan_seen_reg == FAN_NONE) begin
                    fan_first_reg <= rec;
                end else begin
                    fan_prev_reg <= rec;
                end
            end
        end
    end

    a_fan_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        fan_seen_reg != 2'd3)
        else $error("fan vertex count past saturation");

    a_fan_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fan_seen_reg == FAN_FULL && !(accept_i && item_i.op == OP_BEGIN))
            |=> fan_seen_reg == FAN_FULL)
        else $error("fan left full state without begin");

endmodule

// ===== src/qfpa_emit.sv =====
// ----------------------------------------------------------------------------
// qfpa_emit
// Job buffer and result register; sends one vertex per cycle in order while the sink is ready.
// ----------------------------------------------------------------------------
module qfpa_emit import qfpa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load_i,
    input  job_t      job_i,
    output logic      free_o,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    rec_t [JOB_RECS-1:0] buf_reg;
    job_kind_e           kind_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   left_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    logic                out_open;
    logic                advance;
    rec_t                sel_rec;

    assign out_open = !m_valid_reg || m_ready;
    assign advance  = (left_reg != '0) && out_open;
    assign free_o   = (left_reg == '0) || ((left_reg == 3'd1) && out_open);
    assign sel_rec  = buf_reg[rec_slot(kind_reg, step_reg)];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            step_reg    <= '0;
            kind_reg    <= JOB_PASS;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_open) begin
                m_valid_reg <= advance;
            end
            if (load_i) begin
                kind_reg <= job_i.kind;
                step_reg <= '0;
                left_reg <= job_count(job_i.kind);
            end else if (advance) begin
                step_reg <= step_reg + 3'd1;
                left_reg <= left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            buf_reg <= job_i.recs;
        end
        if (advance) begin
            m_data_reg.out_x       <= sel_rec.x;
            m_data_reg.out_y       <= sel_rec.y;
            m_data_reg.out_z       <= sel_rec.z;
            m_data_reg.out_u       <= sel_rec.u;
            m_data_reg.out_v       <= sel_rec.v;
            m_data_reg.out_r       <= sel_rec.r;
            m_data_reg.out_g       <= sel_rec.g;
            m_data_reg.out_b       <= sel_rec.b;
            m_data_reg.out_a       <= sel_rec.a;
            m_data_reg.last_of_run <= (left_reg == 3'd1);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= CNT_QUAD)
        else $error("pending vertex count out of range");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |-> free_o)
        else $error("job loaded over unfinished job");

    a_pending_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg != '0 && !m_valid_reg) |=> m_valid_reg)
        else $error("pending vertex not presented");

endmodule

// ===== src/quad_fan_primitive_assembler_core.sv =====
// Results: a vertex that completes a primitive is loaded into the job buffer, and its results then
// pass through the result register, one per cycle while m_ready allows (1, 3 or 6 per item).
// Throughput: items that emit nothing are taken every cycle, even while results drain;
// an emitting item waits until the job buffer is empty or is sending its last result.
// Reset: aresetn synchronous active low; pass-through mode, colour 1.0, texcoord 0.
// ----------------------------------------------------------------------------
// quad_fan_primitive_assembler_core
// Immediate-mode vertex assembler: pass-through, quad list and triangle fan.
// ----------------------------------------------------------------------------
module quad_fan_primitive_assembler_core import qfpa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic emits;
    logic job_free;
    logic accept;
    logic job_load;
    job_t job;

    // items that produce no result never wait on the output side
    assign s_ready  = job_free || !emits;
    assign accept   = s_valid && s_ready;
    assign job_load = accept && emits;

    qfpa_state u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept_i (accept),
        .item_i   (s_data),
        .emits_o  (emits),
        .job_o    (job)
    );

    qfpa_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load_i  (job_load),
        .job_i   (job),
        .free_o  (job_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sim/quad_fan_primitive_assembler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_fan_primitive_assembler_core_tb
// Self-checking bench: drives begin, colour, texcoord, vertex and spare-opcode items with
// random idling on both channels. A scoreboard keeps its own copy of the
// latched attributes, quad buffer and fan state, and checks every emitted
// vertex in order.
// ----------------------------------------------------------------------------
import qfpa_pkg::*;

class assembly_scoreboard;
    logic [1:0] mode;
    rec_t       latched;
    rec_t       quad_recs [4];
    logic [1:0] quad_fill;
    rec_t       fan_first;
    rec_t       fan_prev;
    logic [1:0] fan_seen;
    out_item_t  pending_vertices [$];
    int         errors;
    int         items_seen;
    int         vertices_checked;
    int         quads_closed;
    int         fan_tris;

    function new();
        mode      = MODE_PASS;
        latched   = '0;
        latched.r = ONE_F32;
        latched.g = ONE_F32;
        latched.b = ONE_F32;
        latched.a = ONE_F32;
        quad_fill = '0;
        fan_seen  = FAN_NONE;
        fan_first = '0;
        fan_prev  = '0;
        foreach (quad_recs[i]) quad_recs[i] = '0;
        errors = 0;
        items_seen = 0;
        vertices_checked = 0;
        quads_closed = 0;
        fan_tris = 0;
    endfunction

    function void emit(rec_t rec, bit last);
        out_item_t o;
        o = {rec, last};
        pending_vertices = {pending_vertices, o};
    endfunction

    function void note_item(in_item_t it);
        rec_t rec;
        items_seen++;
        case (it.op)
            OP_BEGIN: begin
                mode      = it.prim_mode;
                quad_fill = '0;
                fan_seen  = FAN_NONE;
            end
            OP_RGBA, OP_RGB: begin
                latched.r = it.col_r;
                latched.g = it.col_g;
                latched.b = it.col_b;
                latched.a = (it.op == OP_RGBA) ? it.col_a : ONE_F32;
            end
            OP_TEX: begin
                latched.u = it.tex_u;
                latched.v = it.tex_v;
            end
            OP_VERTEX: begin
                latched.x = it.pos_x;
                latched.y = it.pos_y;
                latched.z = it.pos_z;
                rec = latched;
                if (mode == MODE_QUADS) begin
                    quad_recs[quad_fill] = rec;
                    if (quad_fill == QUAD_LAST) begin
                        emit(quad_recs[0], 1'b0);
                        emit(quad_recs[1], 1'b0);
                        emit(quad_recs[2], 1'b0);
                        emit(quad_recs[0], 1'b0);
                        emit(quad_recs[2], 1'b0);
                        emit(quad_recs[3], 1'b1);
                        quad_fill = '0;
                        quads_closed++;
                    end else begin
                        quad_fill = quad_fill + 2'd1;
                    end
                end else if (mode == MODE_FAN) begin
                    if (fan_seen == FAN_NONE) begin
                        fan_first = rec;
                        fan_seen  = FAN_ONE;
                    end else if (fan_seen == FAN_ONE) begin
                        fan_prev = rec;
                        fan_seen = FAN_FULL;
                    end else begin
                        emit(fan_first, 1'b0);
                        emit(fan_prev, 1'b0);
                        emit(rec, 1'b1);
                        fan_prev = rec;
                        fan_tris++;
                    end
                end else begin
                    // pass-through, including the spare mode
                    emit(rec, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    function void check_vertex(out_item_t got);
        out_item_t want;
        if (pending_vertices.size() == 0) begin
            errors++;
            if (errors <= 40)
                $display("%0t: unexpected vertex, expected none actual %h", $time, got);
            return;
        end
        want = pending_vertices.pop_front();
        vertices_checked++;
        compare_field("out_x", want.out_x, got.out_x);
        compare_field("out_y", want.out_y, got.out_y);
        compare_field("out_z", want.out_z, got.out_z);
        compare_field("out_u", want.out_u, got.out_u);
        compare_field("out_v", want.out_v, got.out_v);
        compare_field("out_r", want.out_r, got.out_r);
        compare_field("out_g", want.out_g, got.out_g);
        compare_field("out_b", want.out_b, got.out_b);
        compare_field("out_a", want.out_a, got.out_a);
        compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
endclass

module quad_fan_primitive_assembler_core_tb;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         HOLD_CYCLES = 300;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    assembly_scoreboard sb;

    bit src_calm;
    bit snk_calm;
    bit hold_req;
    bit hold_done;

    quad_fan_primitive_assembler_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [31:0] word_pick();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // don't-care fields carry random bits so every input bit toggles
    function automatic in_item_t rand_item();
        in_item_t it;
        it.op        = 3'($urandom);
        it.prim_mode = 2'($urandom);
        it.pos_x     = $urandom;
        it.pos_y     = $urandom;
        it.pos_z     = $urandom;
        it.tex_u     = $urandom;
        it.tex_v     = $urandom;
        it.col_r     = $urandom;
        it.col_g     = $urandom;
        it.col_b     = $urandom;
        it.col_a     = $urandom;
        return it;
    endfunction

    function automatic in_item_t mk_begin(logic [1:0] mode);
        in_item_t it;
        it = rand_item();
        it.op = OP_BEGIN;
        it.prim_mode = mode;
        return it;
    endfunction

    function automatic in_item_t mk_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_item_t it;
        it = rand_item();
        it.op    = OP_VERTEX;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    function automatic in_item_t mk_colour(op_e op, logic [31:0] r, logic [31:0] g,
                                           logic [31:0] b, logic [31:0] a);
        in_item_t it;
        it = rand_item();
        it.op    = op;
        it.col_r = r;
        it.col_g = g;
        it.col_b = b;
        it.col_a = a;
        return it;
    endfunction

    function automatic in_item_t mk_tex(logic [31:0] u, logic [31:0] v);
        in_item_t it;
        it = rand_item();
        it.op    = OP_TEX;
        it.tex_u = u;
        it.tex_v = v;
        return it;
    endfunction

    function automatic in_item_t mk_spare(logic [2:0] op);
        in_item_t it;
        it = rand_item();
        it.op = op;
        return it;
    endfunction

    // valid is only dropped when a gap follows, never lowered and raised in one step
    task automatic push_item(input in_item_t it);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
    endtask

    task automatic push_random_vertex();
        push_item(mk_vertex(word_pick(), word_pick(), word_pick()));
    endtask

    task automatic push_attr();
        case ($urandom_range(0, 2))
            0:       push_item(mk_colour(OP_RGBA, word_pick(), word_pick(), word_pick(),
                                         word_pick()));
            1:       push_item(mk_colour(OP_RGB, word_pick(), word_pick(), word_pick(),
                                         word_pick()));
            default: push_item(mk_tex(word_pick(), word_pick()));
        endcase
    endtask

    task automatic run_directed();
        // pass-through with the reset attributes
        push_item(mk_vertex('1, '0, '1));
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            push_item(mk_spare(3'(op)));
        push_item(mk_tex('1, '0));
        push_item(mk_colour(OP_RGBA, '1, '0, '1, '0));
        push_item(mk_vertex('0, '0, '0));
        // alpha must come back as 1.0 whatever is on col_a
        push_item(mk_colour(OP_RGB, '0, '1, '0, '0));
        push_item(mk_begin(MODE_QUADS));
        push_item(mk_vertex(32'h0000_0001, 32'h0000_0002, 32'h0000_0003));
        push_item(mk_vertex(32'h0000_0011, 32'h0000_0012, 32'h0000_0013));
        push_item(mk_tex('0, '1));
        push_item(mk_vertex(32'h0000_0021, 32'h0000_0022, 32'h0000_0023));
        push_item(mk_vertex(32'h0000_0031, 32'h0000_0032, 32'h0000_0033));
        // partial quad dropped by the next begin
        push_item(mk_begin(MODE_QUADS));
        push_item(mk_vertex('1, '1, '1));
        push_item(mk_vertex('0, '1, '0));
        push_item(mk_begin(MODE_FAN));
        push_item(mk_vertex(32'h0000_0101, 32'h0000_0102, 32'h0000_0103));
        push_item(mk_vertex(32'h0000_0201, 32'h0000_0202, 32'h0000_0203));
        push_item(mk_vertex(32'h0000_0301, 32'h0000_0302, 32'h0000_0303));
        push_item(mk_colour(OP_RGBA, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, '1));
        push_item(mk_vertex(32'h0000_0401, 32'h0000_0402, 32'h0000_0403));
        // spare mode behaves as pass-through
        push_item(mk_begin(MODE_SPARE));
        push_random_vertex();
        push_item(mk_begin(MODE_PASS));
        push_random_vertex();
    endtask

    // sink holds off while quads and fans are offered back to back
    task automatic run_pressure();
        src_calm = 1'b1;
        hold_req = 1'b1;
        push_item(mk_begin(MODE_QUADS));
        repeat (12) push_random_vertex();
        push_item(mk_begin(MODE_FAN));
        repeat (6) push_random_vertex();
        src_calm = 1'b0;
    endtask

    task automatic run_random(input int target);
        int sent;
        int kind;
        int n;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 5) == 0) src_calm = ~src_calm;
            if ($urandom_range(0, 5) == 0) snk_calm = ~snk_calm;
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                if (kind < 4) begin
                    push_item(mk_begin(MODE_QUADS));
                    // one sequence in four is cut short
                    n = (kind == 0) ? $urandom_range(1, 3) : 4 * $urandom_range(1, 2);
                end else if (kind < 7) begin
                    push_item(mk_begin(MODE_FAN));
                    n = $urandom_range(1, 6);
                end else begin
                    push_item(mk_begin($urandom_range(0, 1) ? MODE_PASS : MODE_SPARE));
                    n = $urandom_range(1, 3);
                end
                sent++;
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        push_attr();
                        sent++;
                    end
                    push_random_vertex();
                    sent++;
                end
            end else if (kind == 8) begin
                push_item(mk_spare(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
                sent++;
            end else begin
                // stray items in whatever mode is active
                push_attr();
                push_random_vertex();
                sent += 2;
            end
        end
        src_calm = 1'b0;
        snk_calm = 1'b0;
    endtask

    initial begin
        int stall_left;
        m_ready    = 1'b0;
        hold_done  = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap(snk_calm);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_vertex(m_data);
    end

    initial begin
        #(5_000_000);
        $display("quad_fan_primitive_assembler_core_tb: FAIL");
        $finish;
    end

    initial begin
        sb       = new();
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        src_calm = 1'b0;
        snk_calm = 1'b0;
        hold_req = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_pressure();
        run_random(85);
        s_valid <= 1'b0;
        while (sb.pending_vertices.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("run covered %0d items: %0d vertices checked, %0d quads, %0d fan triangles",
                 sb.items_seen, sb.vertices_checked, sb.quads_closed, sb.fan_tris);
        if (sb.errors == 0) begin
            $display("quad_fan_primitive_assembler_core_tb: PASS");
        end else begin
            $display("quad_fan_primitive_assembler_core_tb: FAIL");
        end
        $finish;
    end

endmodule
